FILE: src/tnt_pkg.sv
package tnt_pkg;

  localparam int POS_W = 16;
  localparam int EDGE_W = POS_W + 1;
  localparam int PROD_W = 2 * EDGE_W + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 35;
  localparam int DIV_Q_W = 17;

  localparam logic [1:0] MODE_NORMAL_ONLY = 2'd0;
  localparam logic [1:0] MODE_TANGENT_ONLY = 2'd1;
  localparam logic [1:0] MODE_BOTH = 2'd2;

  localparam logic REG_OUTPUT_MODE = 1'b0;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic zero_area;
    logic zero_uv_det;
    logic tangent_clipped;
  } out_item_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] e1x;
    logic signed [EDGE_W-1:0] e1y;
    logic signed [EDGE_W-1:0] e1z;
    logic signed [EDGE_W-1:0] e2x;
    logic signed [EDGE_W-1:0] e2y;
    logic signed [EDGE_W-1:0] e2z;
    logic signed [EDGE_W-1:0] du1;
    logic signed [EDGE_W-1:0] dv1;
    logic signed [EDGE_W-1:0] du2;
    logic signed [EDGE_W-1:0] dv2;
  } tri_t;

  typedef struct packed {
    logic start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
    logic [DIV_Q_W-1:0] q;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_MAG,
    BK_NORM,
    BK_SQ,
    BK_SQRT,
    BK_NDIV,
    BK_TDIV
  } back_state_t;

endpackage

FILE: src/tnt_front.sv
module tnt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  tnt_pkg::in_item_t in_data,
  output logic             push,
  output tnt_pkg::tri_t    push_data
);

  logic [1:0] slot_r, slot_nxt;
  tnt_pkg::in_item_t c0_r, c1_r;
  logic accept;

  assign accept = in_valid && !in_stall;
  assign push = accept && (slot_r == 2'd2);

  always_comb begin
    slot_nxt = slot_r;
    if (accept) begin
      slot_nxt = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 2'd0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  // hold the first two corners
  always_ff @(posedge clk) begin
    if (accept && slot_r == 2'd0) c0_r <= in_data;
    if (accept && slot_r == 2'd1) c1_r <= in_data;
  end

  always_comb begin
    push_data.e1x = 17'(c1_r.pos_x) - 17'(c0_r.pos_x);
    push_data.e1y = 17'(c1_r.pos_y) - 17'(c0_r.pos_y);
    push_data.e1z = 17'(c1_r.pos_z) - 17'(c0_r.pos_z);
    push_data.e2x = 17'(in_data.pos_x) - 17'(c0_r.pos_x);
    push_data.e2y = 17'(in_data.pos_y) - 17'(c0_r.pos_y);
    push_data.e2z = 17'(in_data.pos_z) - 17'(c0_r.pos_z);
    push_data.du1 = 17'(c1_r.tex_u) - 17'(c0_r.tex_u);
    push_data.dv1 = 17'(c1_r.tex_v) - 17'(c0_r.tex_v);
    push_data.du2 = 17'(in_data.tex_u) - 17'(c0_r.tex_u);
    push_data.dv2 = 17'(in_data.tex_v) - 17'(c0_r.tex_v);
  end

endmodule

FILE: src/tnt_fifo.sv
module tnt_fifo #(
  parameter int DEPTH = tnt_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tnt_pkg::tri_t push_data,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output tnt_pkg::tri_t pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tnt_pkg::tri_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full = (cnt_r == CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

FILE: src/tnt_div.sv
module tnt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tnt_pkg::div_req_t req,
  output tnt_pkg::div_rsp_t rsp
);

  localparam int NW = tnt_pkg::DIV_NUM_W;
  localparam int DW = tnt_pkg::DIV_DEN_W;
  localparam int QW = tnt_pkg::DIV_Q_W;

  logic active_r, done_r, ovf_r;
  logic [4:0] cnt_r;
  logic [DW-1:0] rem_r, den_r;
  logic [QW-1:0] qsh_r;
  logic [DW:0] trial;
  logic take;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_r, qsh_r[QW-1]};
  assign take = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        active_r <= 1'b1;
      end else if (active_r && cnt_r == 5'(QW - 1)) begin
        active_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      den_r <= req.den;
      ovf_r <= ({4'b0, req.num[NW-1:QW]} >= req.den);
      rem_r <= {4'b0, req.num[NW-1:QW]};
      qsh_r <= req.num[QW-1:0];
    end else if (active_r) begin
      cnt_r <= cnt_r + 5'd1;
      rem_r <= take ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      qsh_r <= {qsh_r[QW-2:0], take};
    end
  end

  assign rsp.busy = active_r;
  assign rsp.done = done_r;
  assign rsp.ovf = ovf_r;
  assign rsp.q = qsh_r;

endmodule

FILE: src/tnt_back.sv
module tnt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tri_valid,
  input  tnt_pkg::tri_t      tri_data,
  output logic               tri_pop,
  input  logic [1:0]         mode,
  output logic               res_valid,
  output tnt_pkg::out_item_t res,
  input  logic               res_take
);

  localparam int PW = tnt_pkg::PROD_W;

  tnt_pkg::back_state_t state_r, state_nxt;
  tnt_pkg::tri_t tri_r;
  logic [3:0] cnt_r;
  logic mvalid_r;
  logic [3:0] mtag_r;
  logic signed [61:0] mul_r, acc_r, prod;
  logic signed [30:0] a_op, b_op;
  logic signed [PW-1:0] res_r [7];
  logic [33:0] m_r [3];
  logic [63:0] x_r, r_r, bit_r, rb, x_nxt, r_nxt;
  logic [4:0] k_r;
  logic [30:0] len_r;
  logic [1:0] i_r;
  logic [2:0] nidx;
  logic dwait_r, done_r;
  logic zn_r, zd_r, clip_r;
  logic signed [15:0] nrm_r [3];
  logic signed [15:0] tan_r [3];
  logic issue, hi, in_range;
  logic [33:0] nmag, dmag;
  logic nneg;
  logic [16:0] q;
  tnt_pkg::div_req_t dreq;
  tnt_pkg::div_rsp_t drsp;
  logic want_n, want_t;

  function automatic logic signed [30:0] sx(input logic signed [16:0] v);
    return {{14{v[16]}}, v};
  endfunction

  function automatic logic [33:0] absv(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] n;
    n = v[PW-1] ? -v : v;
    return n[33:0];
  endfunction

  tnt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // operand select for the shared multiplier
  always_comb begin
    a_op = '0;
    b_op = '0;
    if (state_r == tnt_pkg::BK_SQ) begin
      a_op = {1'b0, m_r[cnt_r[1:0]][29:0]};
      b_op = {1'b0, m_r[cnt_r[1:0]][29:0]};
    end else begin
      case (cnt_r)
        4'd0: begin a_op = sx(tri_r.e1y); b_op = sx(tri_r.e2z); end
        4'd1: begin a_op = sx(tri_r.e1z); b_op = sx(tri_r.e2y); end
        4'd2: begin a_op = sx(tri_r.e1z); b_op = sx(tri_r.e2x); end
        4'd3: begin a_op = sx(tri_r.e1x); b_op = sx(tri_r.e2z); end
        4'd4: begin a_op = sx(tri_r.e1x); b_op = sx(tri_r.e2y); end
        4'd5: begin a_op = sx(tri_r.e1y); b_op = sx(tri_r.e2x); end
        4'd6: begin a_op = sx(tri_r.du1); b_op = sx(tri_r.dv2); end
        4'd7: begin a_op = sx(tri_r.du2); b_op = sx(tri_r.dv1); end
        4'd8: begin a_op = sx(tri_r.e1x); b_op = sx(tri_r.dv2); end
        4'd9: begin a_op = sx(tri_r.e2x); b_op = sx(tri_r.dv1); end
        4'd10: begin a_op = sx(tri_r.e1y); b_op = sx(tri_r.dv2); end
        4'd11: begin a_op = sx(tri_r.e2y); b_op = sx(tri_r.dv1); end
        4'd12: begin a_op = sx(tri_r.e1z); b_op = sx(tri_r.dv2); end
        4'd13: begin a_op = sx(tri_r.e2z); b_op = sx(tri_r.dv1); end
        default: begin a_op = '0; b_op = '0; end
      endcase
    end
  end

  assign prod = a_op * b_op;
  assign issue = (state_r == tnt_pkg::BK_MUL && cnt_r <= 4'd13) ||
                 (state_r == tnt_pkg::BK_SQ && cnt_r <= 4'd2);

  assign hi = |{m_r[0][33:30], m_r[1][33:30], m_r[2][33:30]};
  assign in_range = |{m_r[0][33:29], m_r[1][33:29], m_r[2][33:29]};

  // integer square root step
  assign rb = r_r + bit_r;
  always_comb begin
    if (x_r >= rb) begin
      x_nxt = x_r - rb;
      r_nxt = (r_r >> 1) + bit_r;
    end else begin
      x_nxt = x_r;
      r_nxt = r_r >> 1;
    end
  end

  assign nidx = 3'(i_r) + 3'd4;
  assign nmag = absv(res_r[nidx]);
  assign dmag = absv(res_r[3]);
  assign nneg = res_r[nidx][PW-1] ^ res_r[3][PW-1];
  assign q = drsp.q;

  always_comb begin
    dreq.start = !dwait_r && drsp.done == 1'b0 &&
                 (state_r == tnt_pkg::BK_NDIV ||
                  (state_r == tnt_pkg::BK_TDIV && res_r[3] != '0));
    if (state_r == tnt_pkg::BK_NDIV) begin
      dreq.num = 48'({m_r[i_r][29:0], 14'b0}) + 48'(len_r >> 1);
      dreq.den = 35'(len_r);
    end else begin
      dreq.num = 48'({nmag, 12'b0}) + 48'(dmag >> 1);
      dreq.den = 35'(dmag);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tnt_pkg::BK_IDLE: if (tri_valid && !done_r) state_nxt = tnt_pkg::BK_MUL;
      tnt_pkg::BK_MUL: if (mvalid_r && mtag_r == 4'd13) state_nxt = tnt_pkg::BK_MAG;
      tnt_pkg::BK_MAG: state_nxt = tnt_pkg::BK_NORM;
      tnt_pkg::BK_NORM: begin
        if (zn_r) state_nxt = tnt_pkg::BK_TDIV;
        else if (!hi && in_range) state_nxt = tnt_pkg::BK_SQ;
      end
      tnt_pkg::BK_SQ: if (mvalid_r && mtag_r == 4'd2) state_nxt = tnt_pkg::BK_SQRT;
      tnt_pkg::BK_SQRT: if (k_r == 5'd0) state_nxt = tnt_pkg::BK_NDIV;
      tnt_pkg::BK_NDIV: if (drsp.done && i_r == 2'd2) state_nxt = tnt_pkg::BK_TDIV;
      tnt_pkg::BK_TDIV: begin
        if (res_r[3] == '0 || (drsp.done && i_r == 2'd2)) state_nxt = tnt_pkg::BK_IDLE;
      end
      default: state_nxt = tnt_pkg::BK_IDLE;
    endcase
  end

  assign tri_pop = (state_r == tnt_pkg::BK_IDLE) && tri_valid && !done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tnt_pkg::BK_IDLE;
      mvalid_r <= 1'b0;
      dwait_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mvalid_r <= issue;
      if (dreq.start) dwait_r <= 1'b1;
      else if (drsp.done) dwait_r <= 1'b0;
      if (state_r == tnt_pkg::BK_TDIV && state_nxt == tnt_pkg::BK_IDLE) done_r <= 1'b1;
      else if (res_take) done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= prod;
    mtag_r <= cnt_r;
    if (issue) cnt_r <= cnt_r + 4'd1;
    case (state_r)
      tnt_pkg::BK_IDLE: begin
        // hold the finished result until it has been handed on
        if (!done_r) begin
          tri_r <= tri_data;
          cnt_r <= '0;
          zn_r <= 1'b0;
          zd_r <= 1'b0;
          clip_r <= 1'b0;
          i_r <= '0;
          for (int j = 0; j < 3; j++) begin
            nrm_r[j] <= '0;
            tan_r[j] <= '0;
          end
        end
      end
      tnt_pkg::BK_MUL: begin
        if (mvalid_r) begin
          if (!mtag_r[0]) acc_r <= mul_r;
          else res_r[mtag_r[3:1]] <= PW'(acc_r - mul_r);
        end
      end
      tnt_pkg::BK_MAG: begin
        for (int j = 0; j < 3; j++) m_r[j] <= absv(res_r[j]);
        zn_r <= (res_r[0] == '0) && (res_r[1] == '0) && (res_r[2] == '0);
      end
      tnt_pkg::BK_NORM: begin
        // scale all three magnitudes so the max is in [2^29, 2^30)
        if (!zn_r) begin
          if (hi) begin
            for (int j = 0; j < 3; j++) m_r[j] <= m_r[j] >> 1;
          end else if (!in_range) begin
            for (int j = 0; j < 3; j++) m_r[j] <= m_r[j] << 1;
          end
        end
        cnt_r <= '0;
      end
      tnt_pkg::BK_SQ: begin
        if (mvalid_r) begin
          if (mtag_r == 4'd0) acc_r <= mul_r;
          else acc_r <= acc_r + mul_r;
          if (mtag_r == 4'd2) begin
            x_r <= 64'(acc_r + mul_r);
            r_r <= '0;
            bit_r <= 64'd1 << 62;
            k_r <= 5'd31;
          end
        end
      end
      tnt_pkg::BK_SQRT: begin
        x_r <= x_nxt;
        r_r <= r_nxt;
        bit_r <= bit_r >> 2;
        k_r <= k_r - 5'd1;
        if (k_r == 5'd0) len_r <= r_nxt[30:0];
      end
      tnt_pkg::BK_NDIV: begin
        if (drsp.done) begin
          nrm_r[i_r] <= res_r[i_r][PW-1] ? -16'(q) : 16'(q);
          i_r <= (i_r == 2'd2) ? 2'd0 : i_r + 2'd1;
        end
      end
      tnt_pkg::BK_TDIV: begin
        if (res_r[3] == '0) begin
          zd_r <= 1'b1;
        end else if (drsp.done) begin
          if (nneg) begin
            if (drsp.ovf || q > 17'd32768) begin
              tan_r[i_r] <= 16'sh8000;
              clip_r <= 1'b1;
            end else begin
              tan_r[i_r] <= -16'(q);
            end
          end else begin
            if (drsp.ovf || q > 17'd32767) begin
              tan_r[i_r] <= 16'sh7fff;
              clip_r <= 1'b1;
            end else begin
              tan_r[i_r] <= 16'(q);
            end
          end
          i_r <= i_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign want_n = (mode != tnt_pkg::MODE_TANGENT_ONLY);
  assign want_t = (mode != tnt_pkg::MODE_NORMAL_ONLY);
  assign res_valid = done_r;

  always_comb begin
    res.normal_x = want_n ? nrm_r[0] : '0;
    res.normal_y = want_n ? nrm_r[1] : '0;
    res.normal_z = want_n ? nrm_r[2] : '0;
    res.tangent_x = want_t ? tan_r[0] : '0;
    res.tangent_y = want_t ? tan_r[1] : '0;
    res.tangent_z = want_t ? tan_r[2] : '0;
    res.zero_area = want_n && zn_r;
    res.zero_uv_det = want_t && zd_r;
    res.tangent_clipped = want_t && clip_r;
  end

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> !drsp.busy)
    else $error("divider started while busy");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    tri_pop |-> state_r == tnt_pkg::BK_IDLE && !res_valid)
    else $error("triangle taken while busy");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res.normal_x <= 16'sd16384 && res.normal_x >= -16'sd16384 &&
                  res.normal_z <= 16'sd16384 && res.normal_z >= -16'sd16384)
    else $error("normal component out of range");

  a_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.zero_uv_det |-> !res.tangent_clipped && res.tangent_x == '0)
    else $error("flat uv gave a tangent");

endmodule

FILE: src/triangle_normal_tangent_core.sv
// Work from the third corner's transfer to the result of a regular face is done by the
//   back-end sequencer: 14 products and three squares on one shared multiplier, a
//   one-bit-a-cycle normalize, a 32-step square root and six divisions.
//   A flat face or flat UVs skip work and finish sooner.
// The front end keeps taking corners while the queue has room; the back end works on one triangle at a time.
// Reset (rst_n low, synchronous) empties the queue, restarts at the first corner, both outputs.
module triangle_normal_tangent_core #(
  parameter int QUEUE_DEPTH = tnt_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tnt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tnt_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [1:0] mode_r;
  logic push, q_full, q_valid, q_pop;
  tnt_pkg::tri_t push_data, q_data;
  logic res_valid, res_take;
  tnt_pkg::out_item_t res;
  logic out_valid_r;
  tnt_pkg::out_item_t out_data_r;

  // Register file: one mode register at byte address 0.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == tnt_pkg::REG_OUTPUT_MODE) ? {30'b0, mode_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tnt_pkg::MODE_BOTH;
    end else if (psel && penable && pwrite && paddr[2] == tnt_pkg::REG_OUTPUT_MODE) begin
      mode_r <= pwdata[1:0];
    end
  end

  // Front end: hold the first two corners, turn the third into edges and push.
  // Stall input whenever the queue is full.
  assign in_stall = q_full;

  tnt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .push(push), .push_data(push_data)
  );

  tnt_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(q_full),
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_data)
  );

  // Back end: one triangle at a time through multiplier, root and divider.
  tnt_back u_back (
    .clk(clk), .rst_n(rst_n), .tri_valid(q_valid), .tri_data(q_data), .tri_pop(q_pop),
    .mode(mode_r), .res_valid(res_valid), .res(res), .res_take(res_take)
  );

  // Output register: load a finished result when the slot is free or drains this cycle.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> !(out_valid_r && out_stall))
    else $error("result loaded over a pending one");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> in_stall && !push)
    else $error("push into full queue");

endmodule

FILE: sim/tnt_checker.sv
module tnt_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tnt_pkg::in_item_t   in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tnt_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending
);

  logic signed [15:0] corner_pos [2][3];
  logic signed [15:0] corner_uv [2][2];
  int unsigned        corner_idx;
  logic [1:0]         mode_reg;
  tnt_pkg::out_item_t face_q[$];

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Face normal and tangent of the triangle closed by corner three.
  function automatic tnt_pkg::out_item_t face_result(tnt_pkg::in_item_t c3);
    tnt_pkg::out_item_t r;
    longint          e1[3], e2[3], cr[3], p3[3], du1, dv1, du2, dv2, det, num;
    longint unsigned m[3], mx, len, d, q;
    logic signed [15:0] nv[3], tv[3];
    logic            za, zd, clip, neg, want_n, want_t;
    p3[0] = c3.pos_x; p3[1] = c3.pos_y; p3[2] = c3.pos_z;
    za = 0; zd = 0; clip = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(corner_pos[1][i]) - longint'(corner_pos[0][i]);
      e2[i] = p3[i] - longint'(corner_pos[0][i]);
      nv[i] = 0;
      tv[i] = 0;
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(cr[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      za = 1;
    end else begin
      // scale so the largest component sits in [2^29, 2^30)
      while (mx >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        mx = mx >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        mx = mx << 1;
      end
      len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 16384 + len / 2) / len;
        nv[i] = (cr[i] < 0) ? -16'(q) : 16'(q);
      end
    end
    du1 = longint'(corner_uv[1][0]) - longint'(corner_uv[0][0]);
    dv1 = longint'(corner_uv[1][1]) - longint'(corner_uv[0][1]);
    du2 = longint'(c3.tex_u) - longint'(corner_uv[0][0]);
    dv2 = longint'(c3.tex_v) - longint'(corner_uv[0][1]);
    det = du1 * dv2 - du2 * dv1;
    if (det == 0) begin
      zd = 1;
    end else begin
      d = mag(det);
      for (int i = 0; i < 3; i++) begin
        num = e1[i] * dv2 - e2[i] * dv1;
        neg = (num < 0) != (det < 0);
        q = ((mag(num) << 12) + d / 2) / d;
        if (neg) begin
          if (q > 32768) begin
            q = 32768;
            clip = 1;
          end
          tv[i] = -16'(q);
        end else begin
          if (q > 32767) begin
            q = 32767;
            clip = 1;
          end
          tv[i] = 16'(q);
        end
      end
    end
    want_n = mode_reg != tnt_pkg::MODE_TANGENT_ONLY;
    want_t = mode_reg != tnt_pkg::MODE_NORMAL_ONLY;
    r.normal_x = want_n ? nv[0] : '0;
    r.normal_y = want_n ? nv[1] : '0;
    r.normal_z = want_n ? nv[2] : '0;
    r.tangent_x = want_t ? tv[0] : '0;
    r.tangent_y = want_t ? tv[1] : '0;
    r.tangent_z = want_t ? tv[2] : '0;
    r.zero_area = want_n & za;
    r.zero_uv_det = want_t & zd;
    r.tangent_clipped = want_t & clip;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = face_q.size();

  always @(posedge clk) begin
    tnt_pkg::out_item_t w;
    if (!rst_n) begin
      corner_idx = 0;
      mode_reg = tnt_pkg::MODE_BOTH;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 3; j++) corner_pos[i][j] = 0;
        corner_uv[i][0] = 0;
        corner_uv[i][1] = 0;
      end
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == tnt_pkg::REG_OUTPUT_MODE)
        mode_reg = pwdata[1:0];
      if (in_valid && !in_stall) begin
        if (corner_idx < 2) begin
          corner_pos[corner_idx][0] = in_data.pos_x;
          corner_pos[corner_idx][1] = in_data.pos_y;
          corner_pos[corner_idx][2] = in_data.pos_z;
          corner_uv[corner_idx][0] = in_data.tex_u;
          corner_uv[corner_idx][1] = in_data.tex_v;
          corner_idx++;
        end else begin
          face_q.push_back(face_result(in_data));
          corner_idx = 0;
        end
      end
      if (out_valid && !out_stall) begin
        if (face_q.size() == 0) begin
          report("unexpected result transfer", 1, 0);
        end else begin
          w = face_q.pop_front();
          if (out_data.normal_x !== w.normal_x) report("normal_x", out_data.normal_x, w.normal_x);
          if (out_data.normal_y !== w.normal_y) report("normal_y", out_data.normal_y, w.normal_y);
          if (out_data.normal_z !== w.normal_z) report("normal_z", out_data.normal_z, w.normal_z);
          if (out_data.tangent_x !== w.tangent_x)
            report("tangent_x", out_data.tangent_x, w.tangent_x);
          if (out_data.tangent_y !== w.tangent_y)
            report("tangent_y", out_data.tangent_y, w.tangent_y);
          if (out_data.tangent_z !== w.tangent_z)
            report("tangent_z", out_data.tangent_z, w.tangent_z);
          if (out_data.zero_area !== w.zero_area)
            report("zero_area", out_data.zero_area, w.zero_area);
          if (out_data.zero_uv_det !== w.zero_uv_det)
            report("zero_uv_det", out_data.zero_uv_det, w.zero_uv_det);
          if (out_data.tangent_clipped !== w.tangent_clipped)
            report("tangent_clipped", out_data.tangent_clipped, w.tangent_clipped);
        end
      end
    end
  end
endmodule

FILE: sim/testbench.sv
module testbench;

  // 2'd3 is not a named mode; the block must treat it as both outputs
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // byte address of the mode register
  localparam logic [2:0] ADDR_OUTPUT_MODE = {tnt_pkg::REG_OUTPUT_MODE, 2'b00};
  // byte address of a register index the block must ignore
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 260;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  tnt_pkg::in_item_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  tnt_pkg::out_item_t out_data;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          quiet = 0;

  always #5 clk = ~clk;

  triangle_normal_tangent_core dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tnt_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall at random except during the quiet stretch.
  always @(posedge clk)
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 12);

  // Drive one vertex and hold it until the transfer completes.
  task automatic push_corner(tnt_pkg::in_item_t v);
    bit took;
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    forever begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
      if (took) break;
    end
  endtask

  task automatic corner(int px, int py, int pz, int u, int v);
    tnt_pkg::in_item_t c;
    c.pos_x = 16'(px); c.pos_y = 16'(py); c.pos_z = 16'(pz);
    c.tex_u = 16'(u); c.tex_v = 16'(v);
    push_corner(c);
  endtask

  // Hold the sender until every pending face is out, then let the back end settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_field(logic signed [15:0] base);
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return base + 16'($urandom_range(0, 8191)) - 16'sd4096;
      default: return base + 16'($urandom_range(0, 1023)) - 16'sd512;
    endcase
  endfunction

  // A random triangle: mostly nearby corners, sometimes degenerate.
  task automatic random_face();
    tnt_pkg::in_item_t base, c;
    base = tnt_pkg::in_item_t'(80'({$urandom, $urandom, $urandom}));
    for (int k = 0; k < 3; k++) begin
      c.pos_x = rand_field(base.pos_x);
      c.pos_y = rand_field(base.pos_y);
      c.pos_z = rand_field(base.pos_z);
      c.tex_u = rand_field(base.tex_u);
      c.tex_v = rand_field(base.tex_v);
      case ($urandom_range(15))
        0: c = base;
        1: begin
          c.tex_u = base.tex_u;
          c.tex_v = base.tex_v;
        end
        default: ;
      endcase
      push_corner(c);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: plain face, full-scale extremes, degenerate face, clipped tangent, small face.
    corner(0, 0, 0, 0, 0);
    corner(256, 0, 0, 4096, 0);
    corner(0, 256, 0, 0, 4096);
    corner(-32768, -32768, -32768, -32768, -32768);
    corner(32767, 32767, 32767, 32767, 32767);
    corner(32767, -32768, 0, -32768, 32767);
    corner(5, 5, 5, 7, 7);
    corner(5, 5, 5, 7, 7);
    corner(5, 5, 5, 7, 7);
    corner(0, 0, 0, 0, 0);
    corner(32767, 0, 0, 1, 0);
    corner(0, -32768, 0, 0, 1);
    corner(-1, 0, 0, -1, 0);
    corner(0, -1, 0, 0, -1);
    corner(0, 0, -1, 1, 1);

    // Sweep the modes, including the unnamed code and an ignored address.
    drain();
    apb_write(ADDR_OUTPUT_MODE, 32'(tnt_pkg::MODE_NORMAL_ONLY));
    for (int n = 0; n < 40; n++) random_face();
    drain();
    apb_write(ADDR_OUTPUT_MODE, 32'(tnt_pkg::MODE_TANGENT_ONLY));
    apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    for (int n = 0; n < 40; n++) random_face();
    drain();
    apb_write(ADDR_OUTPUT_MODE, 32'(MODE_UNUSED));
    for (int n = 0; n < 30; n++) random_face();
    drain();
    apb_write(ADDR_OUTPUT_MODE, 32'(tnt_pkg::MODE_BOTH));
    quiet = 1;
    for (int n = 0; n < 40; n++) random_face();
    quiet = 0;
    for (int n = 0; n < 100; n++) random_face();

    drain();
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
